// File: rtl/mke_pkg.sv
// Shared types, constants and lookup tables for the Morse keyer encoder.
// Depends on nothing; every other file of the block imports it.
package mke_pkg;

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int DOT_W      = 16;
  localparam int DUR_W      = 19;
  localparam int UNIT_W     = 3;
  localparam int PAT_W      = 7;
  localparam int ELEM_W     = 3;
  localparam int TBL_IDX_W  = 6;

  // Number of symbols held in the fixed table.
  localparam int TBL_SIZE   = 55;

  // Segment lengths in dot units.
  localparam logic [UNIT_W-1:0] UNITS_DOT      = 3'd1;
  localparam logic [UNIT_W-1:0] UNITS_DASH     = 3'd3;
  localparam logic [UNIT_W-1:0] UNITS_ELEM_GAP = 3'd1;
  localparam logic [UNIT_W-1:0] UNITS_SPACE    = 3'd6;
  localparam logic [UNIT_W-1:0] UNITS_CHAR_GAP = 3'd2;

  localparam logic [DOT_W-1:0] DOT_LEN_RESET = 16'd150;

  // Case folding bounds and offset.
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // One symbol: element count and pattern, first element in the MSB,
  // a one meaning dash. The word space is a symbol of its own.
  typedef struct packed {
    logic              space;
    logic [ELEM_W-1:0] len;
    logic [PAT_W-1:0]  pat;
  } mke_sym_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MARK,
    BK_ELEM_GAP,
    BK_WORD_GAP,
    BK_CHAR_GAP
  } mke_bk_state_t;

  // Character held at each table slot.
  function automatic logic [CHAR_W-1:0] mke_char_at(input logic [TBL_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      6'd0:  c = 8'h61;  // a
      6'd1:  c = 8'h62;
      6'd2:  c = 8'h63;
      6'd3:  c = 8'h64;
      6'd4:  c = 8'h65;
      6'd5:  c = 8'h66;
      6'd6:  c = 8'h67;
      6'd7:  c = 8'h68;
      6'd8:  c = 8'h69;
      6'd9:  c = 8'h6a;
      6'd10: c = 8'h6b;
      6'd11: c = 8'h6c;
      6'd12: c = 8'h6d;
      6'd13: c = 8'h6e;
      6'd14: c = 8'h6f;
      6'd15: c = 8'h70;
      6'd16: c = 8'h71;
      6'd17: c = 8'h72;
      6'd18: c = 8'h73;
      6'd19: c = 8'h74;
      6'd20: c = 8'h75;
      6'd21: c = 8'h76;
      6'd22: c = 8'h77;
      6'd23: c = 8'h78;
      6'd24: c = 8'h79;
      6'd25: c = 8'h7a;  // z
      6'd26: c = 8'h30;  // 0
      6'd27: c = 8'h31;
      6'd28: c = 8'h32;
      6'd29: c = 8'h33;
      6'd30: c = 8'h34;
      6'd31: c = 8'h35;
      6'd32: c = 8'h36;
      6'd33: c = 8'h37;
      6'd34: c = 8'h38;
      6'd35: c = 8'h39;  // 9
      6'd36: c = 8'h21;  // !
      6'd37: c = 8'h22;  // double quote
      6'd38: c = 8'h24;  // $
      6'd39: c = 8'h26;  // &
      6'd40: c = 8'h28;  // (
      6'd41: c = 8'h29;  // )
      6'd42: c = 8'h5f;  // _
      6'd43: c = 8'h2b;  // +
      6'd44: c = 8'h3d;  // =
      6'd45: c = 8'h2d;  // -
      6'd46: c = 8'h3a;  // :
      6'd47: c = 8'h3b;  // ;
      6'd48: c = 8'h40;  // @
      6'd49: c = 8'h27;  // apostrophe
      6'd50: c = 8'h2c;  // ,
      6'd51: c = 8'h2e;  // .
      6'd52: c = 8'h2f;  // /
      6'd53: c = 8'h3f;  // ?
      6'd54: c = 8'h20;  // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Morse pattern held at each table slot.
  function automatic mke_sym_t mke_sym_at(input logic [TBL_IDX_W-1:0] idx);
    mke_sym_t s;
    s.space = 1'b0;
    unique case (idx)
      6'd0:  begin s.len = 3'd2; s.pat = 7'b0100000; end  // .-
      6'd1:  begin s.len = 3'd4; s.pat = 7'b1000000; end  // -...
      6'd2:  begin s.len = 3'd4; s.pat = 7'b1010000; end  // -.-.
      6'd3:  begin s.len = 3'd3; s.pat = 7'b1000000; end  // -..
      6'd4:  begin s.len = 3'd1; s.pat = 7'b0000000; end  // .
      6'd5:  begin s.len = 3'd4; s.pat = 7'b0010000; end  // ..-.
      6'd6:  begin s.len = 3'd3; s.pat = 7'b1100000; end  // --.
      6'd7:  begin s.len = 3'd4; s.pat = 7'b0000000; end  // ....
      6'd8:  begin s.len = 3'd2; s.pat = 7'b0000000; end  // ..
      6'd9:  begin s.len = 3'd4; s.pat = 7'b0111000; end  // .---
      6'd10: begin s.len = 3'd3; s.pat = 7'b1010000; end  // -.-
      6'd11: begin s.len = 3'd4; s.pat = 7'b0100000; end  // .-..
      6'd12: begin s.len = 3'd2; s.pat = 7'b1100000; end  // --
      6'd13: begin s.len = 3'd2; s.pat = 7'b1000000; end  // -.
      6'd14: begin s.len = 3'd3; s.pat = 7'b1110000; end  // ---
      6'd15: begin s.len = 3'd4; s.pat = 7'b0110000; end  // .--.
      6'd16: begin s.len = 3'd4; s.pat = 7'b1101000; end  // --.-
      6'd17: begin s.len = 3'd3; s.pat = 7'b0100000; end  // .-.
      6'd18: begin s.len = 3'd3; s.pat = 7'b0000000; end  // ...
      6'd19: begin s.len = 3'd1; s.pat = 7'b1000000; end  // -
      6'd20: begin s.len = 3'd3; s.pat = 7'b0010000; end  // ..-
      6'd21: begin s.len = 3'd4; s.pat = 7'b0001000; end  // ...-
      6'd22: begin s.len = 3'd3; s.pat = 7'b0110000; end  // .--
      6'd23: begin s.len = 3'd4; s.pat = 7'b1001000; end  // -..-
      6'd24: begin s.len = 3'd4; s.pat = 7'b1011000; end  // -.--
      6'd25: begin s.len = 3'd4; s.pat = 7'b1100000; end  // --..
      6'd26: begin s.len = 3'd5; s.pat = 7'b1111100; end  // -----
      6'd27: begin s.len = 3'd5; s.pat = 7'b0111100; end  // .----
      6'd28: begin s.len = 3'd5; s.pat = 7'b0011100; end  // ..---
      6'd29: begin s.len = 3'd5; s.pat = 7'b0001100; end  // ...--
      6'd30: begin s.len = 3'd5; s.pat = 7'b0000100; end  // ....-
      6'd31: begin s.len = 3'd5; s.pat = 7'b0000000; end  // .....
      6'd32: begin s.len = 3'd5; s.pat = 7'b1000000; end  // -....
      6'd33: begin s.len = 3'd5; s.pat = 7'b1100000; end  // --...
      6'd34: begin s.len = 3'd5; s.pat = 7'b1110000; end  // ---..
      6'd35: begin s.len = 3'd5; s.pat = 7'b1111000; end  // ----.
      6'd36: begin s.len = 3'd6; s.pat = 7'b1010110; end  // -.-.--
      6'd37: begin s.len = 3'd6; s.pat = 7'b0100100; end  // .-..-.
      6'd38: begin s.len = 3'd7; s.pat = 7'b0001001; end  // ...-..-
      6'd39: begin s.len = 3'd5; s.pat = 7'b0100000; end  // .-...
      6'd40: begin s.len = 3'd5; s.pat = 7'b1011000; end  // -.--.
      6'd41: begin s.len = 3'd6; s.pat = 7'b1011010; end  // -.--.-
      6'd42: begin s.len = 3'd6; s.pat = 7'b0011010; end  // ..--.-
      6'd43: begin s.len = 3'd5; s.pat = 7'b0101000; end  // .-.-.
      6'd44: begin s.len = 3'd5; s.pat = 7'b1000100; end  // -...-
      6'd45: begin s.len = 3'd6; s.pat = 7'b1000010; end  // -....-
      6'd46: begin s.len = 3'd6; s.pat = 7'b1110000; end  // ---...
      6'd47: begin s.len = 3'd6; s.pat = 7'b1010100; end  // -.-.-.
      6'd48: begin s.len = 3'd6; s.pat = 7'b0110100; end  // .--.-.
      6'd49: begin s.len = 3'd6; s.pat = 7'b0111100; end  // .----.
      6'd50: begin s.len = 3'd6; s.pat = 7'b1100110; end  // --..--
      6'd51: begin s.len = 3'd6; s.pat = 7'b0101010; end  // .-.-.-
      6'd52: begin s.len = 3'd5; s.pat = 7'b1001000; end  // -..-.
      6'd53: begin s.len = 3'd6; s.pat = 7'b0011000; end  // ..--..
      6'd54: begin s.len = 3'd1; s.pat = 7'b0000000; s.space = 1'b1; end
      default: begin s.len = 3'd1; s.pat = 7'b0000000; end
    endcase
    return s;
  endfunction

endpackage

// File: rtl/mke_front.sv
// Front end of the Morse keyer encoder: folds case and finds the table slot.
// Depends on mke_pkg for the character table.
module mke_front
  import mke_pkg::*;
#(
  parameter int TABLE_ENTRIES = 55,
  parameter int IDX_W         = 6
) (
  input  logic [CHAR_W-1:0] character,
  output logic              found,
  output logic [IDX_W-1:0]  idx
);

  logic [CHAR_W-1:0] folded;

  // Upper-case letters map onto lower case; all other codes pass unchanged.
  always_comb begin
    if (character >= CHAR_UPPER_A && character <= CHAR_UPPER_Z) begin
      folded = character + CASE_OFFSET;
    end else begin
      folded = character;
    end
  end

  // Compare against every enabled slot; the lowest matching slot wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int n = TBL_SIZE - 1; n >= 0; n--) begin
      if (n < TABLE_ENTRIES && mke_char_at(TBL_IDX_W'(n)) == folded) begin
        found = 1'b1;
        idx   = IDX_W'(n);
      end
    end
  end

endmodule

// File: rtl/mke_queue.sv
// Two-entry queue of table slots between the front end and the sequencer.
// Depends on mke_pkg only for the shared import convention.
module mke_queue
  import mke_pkg::*;
#(
  parameter int W = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full     = count_r[1];
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/mke_back.sv
// Back end of the Morse keyer encoder: walks one symbol and emits key segments.
// Depends on mke_pkg for the pattern table, unit counts and state type.
module mke_back
  import mke_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [IDX_W-1:0]  q_idx,
  output logic              q_pop,
  input  logic              cfg_we,
  input  logic [DOT_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_key_on,
  output logic [DUR_W-1:0]  out_duration,
  output logic              out_last
);

  mke_bk_state_t     state_r, state_nxt;
  mke_sym_t          sym_r;
  mke_sym_t          q_sym;
  logic [ELEM_W-1:0] elem_r;
  logic [DOT_W-1:0]  dot_len_r;
  logic              out_valid_r;
  logic              key_on_r;
  logic [DUR_W-1:0]  duration_r;
  logic              last_r;
  logic              adv;
  logic              emit;
  logic              seg_on;
  logic              seg_last;
  logic [UNIT_W-1:0] seg_units;
  logic              elem_done;

  assign q_sym     = mke_sym_at(TBL_IDX_W'(q_idx));
  assign adv       = !out_valid_r || !out_stall;
  assign elem_done = (ELEM_W'(elem_r + 3'd1) == sym_r.len);

  // Next state of the segment sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_sym.space ? BK_WORD_GAP : BK_MARK;
        end
      end
      BK_MARK: begin
        if (adv) begin
          state_nxt = BK_ELEM_GAP;
        end
      end
      BK_ELEM_GAP: begin
        if (adv) begin
          state_nxt = elem_done ? BK_CHAR_GAP : BK_MARK;
        end
      end
      BK_WORD_GAP: begin
        if (adv) begin
          state_nxt = BK_CHAR_GAP;
        end
      end
      BK_CHAR_GAP: begin
        if (adv) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Segment chosen in each state.
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    seg_on    = 1'b0;
    seg_last  = 1'b0;
    seg_units = UNITS_ELEM_GAP;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_MARK: begin
        emit      = adv;
        seg_on    = 1'b1;
        seg_units = sym_r.pat[PAT_W-1] ? UNITS_DASH : UNITS_DOT;
      end
      BK_ELEM_GAP: begin
        emit      = adv;
        seg_units = UNITS_ELEM_GAP;
      end
      BK_WORD_GAP: begin
        emit      = adv;
        seg_units = UNITS_SPACE;
      end
      BK_CHAR_GAP: begin
        emit      = adv;
        seg_last  = 1'b1;
        seg_units = UNITS_CHAR_GAP;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state, dot length register and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      dot_len_r   <= DOT_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        dot_len_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Symbol being sent: loaded on pop, pattern shifts after each element gap.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sym_r  <= q_sym;
      elem_r <= '0;
    end else if (state_r == BK_ELEM_GAP && adv) begin
      sym_r.pat <= sym_r.pat << 1;
      elem_r    <= elem_r + 3'd1;
    end
  end

  // Output register; duration is unit count times dot length.
  always_ff @(posedge clk) begin
    if (emit) begin
      key_on_r   <= seg_on;
      duration_r <= DUR_W'(seg_units) * DUR_W'(dot_len_r);
      last_r     <= seg_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_on   = key_on_r;
  assign out_duration = duration_r;
  assign out_last     = last_r;

endmodule

// File: rtl/morse_keyer_encoder.sv
// Top level of the Morse keyer encoder: front end, queue and segment sequencer.
// Depends on mke_pkg, mke_front, mke_queue and mke_back.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall   | in_character
//   out_    | out       | out_valid/out_stall | out_key_on, out_duration, out_last
//   cfg_    | in        | cfg_we              | cfg_wdata (dot length)
//
// A known character of n elements gives 2n+1 segments, one per cycle while
// out_stall is low, once the sequencer has taken it from the queue. A space
// gives two segments; an unknown character is accepted and dropped.
// The segment sequencer sets the rate; the two-entry queue lets the front end
// keep accepting while it runs. Reset empties the queue, clears the output and
// sets the dot length to 150. out_stall holds the output register in place.
module morse_keyer_encoder
  import mke_pkg::*;
#(
  parameter int TABLE_ENTRIES = 55
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_key_on,
  output logic [DUR_W-1:0]  out_duration,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [DOT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic             found;
  logic [IDX_W-1:0] front_idx;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [IDX_W-1:0] q_idx;

  // Classify the incoming character.
  mke_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_front (
    .character(in_character),
    .found    (found),
    .idx      (front_idx)
  );

  // Hold known characters until the sequencer is free.
  mke_queue #(
    .W(IDX_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && found),
    .push_data(front_idx),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_data (q_idx)
  );

  assign in_stall = q_full;

  // Expand each symbol into key segments.
  mke_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_idx       (q_idx),
    .q_pop       (q_pop),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key_on  (out_key_on),
    .out_duration(out_duration),
    .out_last    (out_last)
  );

endmodule

// File: rtl/mke_checker.sv
// Port-level checks for the Morse keyer encoder, bound to the top level.
// Depends on mke_pkg for field widths.
module mke_checker
  import mke_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_key_on,
  input logic [DUR_W-1:0] out_duration,
  input logic             out_last
);

  // A stalled beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_key_on) && $stable(out_duration) && $stable(out_last))
    else $error("output payload changed while stalled");

  // The closing segment of a character is always silence.
  a_last_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_key_on)
    else $error("final segment has the key on");

  // Every tone is followed at once by an element gap.
  a_gap_after_tone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_key_on |=> out_valid && !out_key_on && !out_last)
    else $error("tone not followed by an element gap");

  // Input acceptance is not blocked by an input that is not offered.
  a_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && $past(!in_valid) && $past(!in_stall) |-> !in_stall)
    else $error("input stalled with no item taken");

endmodule

bind morse_keyer_encoder mke_checker u_mke_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_key_on  (out_key_on),
  .out_duration(out_duration),
  .out_last    (out_last)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for morse_keyer_encoder: characters go in, key segments come out.
// Depends on mke_pkg and the RTL of morse_keyer_encoder; it predicts every segment itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mke_pkg::*;

  // One key segment as it appears on the result channel.
  typedef struct packed {
    logic             key_on;
    logic [DUR_W-1:0] duration;
    logic             last;
  } segment_t;

  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned MAX_WAIT     = 16;
  localparam int unsigned SETTLE_CYCLE = 24;
  localparam int unsigned LONG_HOLD    = 400;

  // Letters, digits, punctuation and the word space that the keyer knows.
  localparam string KNOWN_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789!\"$&()_+=-:;@',./? ";

  // Holds the segments still owed by the keyer and checks each one that arrives.
  class segment_ledger;
    segment_t         segments_due[$];
    logic [DOT_W-1:0] dot_len;
    int unsigned      mismatches;

    function new();
      dot_len    = DOT_LEN_RESET;
      mismatches = 0;
    endfunction

    function void set_dot_len(input logic [DOT_W-1:0] value);
      dot_len = value;
    endfunction

    function int unsigned pending();
      return segments_due.size();
    endfunction

    // Dots and dashes of each known lower-case character; a blank means word space.
    function string morse_code(input logic [CHAR_W-1:0] ch);
      case (ch)
        "a": return ".-";
        "b": return "-...";
        "c": return "-.-.";
        "d": return "-..";
        "e": return ".";
        "f": return "..-.";
        "g": return "--.";
        "h": return "....";
        "i": return "..";
        "j": return ".---";
        "k": return "-.-";
        "l": return ".-..";
        "m": return "--";
        "n": return "-.";
        "o": return "---";
        "p": return ".--.";
        "q": return "--.-";
        "r": return ".-.";
        "s": return "...";
        "t": return "-";
        "u": return "..-";
        "v": return "...-";
        "w": return ".--";
        "x": return "-..-";
        "y": return "-.--";
        "z": return "--..";
        "0": return "-----";
        "1": return ".----";
        "2": return "..---";
        "3": return "...--";
        "4": return "....-";
        "5": return ".....";
        "6": return "-....";
        "7": return "--...";
        "8": return "---..";
        "9": return "----.";
        "!": return "-.-.--";
        8'h22: return ".-..-.";
        "$": return "...-..-";
        "&": return ".-...";
        "(": return "-.--.";
        ")": return "-.--.-";
        "_": return "..--.-";
        "+": return ".-.-.";
        "=": return "-...-";
        "-": return "-....-";
        ":": return "---...";
        ";": return "-.-.-.";
        "@": return ".--.-.";
        8'h27: return ".----.";
        ",": return "--..--";
        ".": return ".-.-.-";
        "/": return "-..-.";
        "?": return "..--..";
        " ": return " ";
        default: return "";
      endcase
    endfunction

    function void owe_segment(input logic on, input logic [UNIT_W-1:0] units,
                              input logic last);
      segment_t seg;
      seg.key_on   = on;
      seg.duration = DUR_W'(units) * DUR_W'(dot_len);
      seg.last     = last;
      segments_due.push_back(seg);
    endfunction

    // Expands one accepted character into the segments it must produce.
    function void note_char(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] folded;
      string             code;
      folded = ch;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
        folded = ch + CASE_OFFSET;
      end
      code = morse_code(folded);
      // An unknown character is dropped without a segment.
      if (code.len() == 0) begin
        return;
      end
      for (int i = 0; i < code.len(); i++) begin
        if (code[i] == ".") begin
          owe_segment(1'b1, UNITS_DOT, 1'b0);
          owe_segment(1'b0, UNITS_ELEM_GAP, 1'b0);
        end else if (code[i] == "-") begin
          owe_segment(1'b1, UNITS_DASH, 1'b0);
          owe_segment(1'b0, UNITS_ELEM_GAP, 1'b0);
        end else begin
          owe_segment(1'b0, UNITS_SPACE, 1'b0);
        end
      end
      owe_segment(1'b0, UNITS_CHAR_GAP, 1'b1);
    endfunction

    // Compares an arriving segment with the oldest one owed.
    function void check_segment(input logic key_on, input logic [DUR_W-1:0] duration,
                                input logic last);
      segment_t want;
      if (segments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected segment on=%0b dur=%0d last=%0b",
                   $realtime, key_on, duration, last);
        end
        return;
      end
      want = segments_due.pop_front();
      if (want.key_on !== key_on || want.duration !== duration || want.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display({"%0t: segment mismatch, expected on=%0b dur=%0d last=%0b,",
                    " got on=%0b dur=%0d last=%0b"},
                   $realtime, want.key_on, want.duration, want.last, key_on, duration, last);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] in_character;
  logic              out_valid;
  logic              out_stall;
  logic              out_key_on;
  logic [DUR_W-1:0]  out_duration;
  logic              out_last;
  logic              cfg_we;
  logic [DOT_W-1:0]  cfg_wdata;

  bit rx_idle_on = 1'b1;
  bit rx_hold    = 1'b0;
  bit tx_idle_on = 1'b1;

  segment_ledger ledger = new();

  morse_keyer_encoder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_on   (out_key_on),
    .out_duration (out_duration),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one character after an optional gap and waits for its beat.
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    do @(posedge clk); while (in_stall);
    ledger.note_char(ch);
  endtask

  // Mostly known characters, some upper case and some arbitrary codes.
  task automatic send_random(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_char(KNOWN_CHARS[$urandom_range(0, KNOWN_CHARS.len() - 1)]);
      end else if (pick < 85) begin
        send_char(CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25)));
      end else begin
        send_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Lowers valid and waits until every owed segment is out and the keyer is quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLE) @(posedge clk);
  endtask

  task automatic write_dot_len(input logic [DOT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_dot_len(value);
  endtask

  // Result side: checks each beat and draws a stall before taking the next one.
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        ledger.check_segment(out_key_on, out_duration, out_last);
        wait_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (rx_hold || wait_left > 0) begin
        out_stall <= 1'b1;
        if (!rx_hold) begin
          wait_left--;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed characters, then random phases at several dot lengths.
  initial begin : stimulus
    logic [CHAR_W-1:0] directed [24];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    directed = '{8'h41, 8'h5a, "a", "z", "0", "9", "$", "e", "t", " ",
                 8'h00, 8'hff, 8'h80, 8'h7f, "@", 8'h22, 8'h27, "?",
                 "_", ".", ",", 8'h60, 8'h7b, 8'h5b};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset dot length: field extremes, the longest pattern, space and unknown codes.
    foreach (directed[i]) begin
      send_char(directed[i]);
    end
    wait_drained();

    // Unit length of one, no idling on either side.
    write_dot_len(16'd1);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    send_random(60);
    wait_drained();

    // Longest unit; the receiver holds off long enough for the input to back up.
    write_dot_len(16'hffff);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    tx_idle_on = 1'b0;
    send_random(30);
    tx_idle_on = 1'b1;
    send_random(30);
    wait_drained();

    // Zero unit length gives zero durations throughout.
    write_dot_len(16'd0);
    tx_idle_on = 1'b0;
    send_random(40);
    wait_drained();

    // A random unit length with a busy sender and an eager receiver.
    write_dot_len(DOT_W'($urandom_range(2, 65534)));
    rx_idle_on <= 1'b0;
    send_random(80);
    wait_drained();

    // Small unit length with gaps on both sides.
    write_dot_len(16'd2);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    send_random(80);
    wait_drained();

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
